FILE: hdl/itp_pkg.sv
// itp_pkg: shared types and constants of the integer text parser.
// Character codes, radix codes and the token that moves from front to back.
// Depends on nothing.
package itp_pkg;

  localparam int unsigned CH_W    = 8;
  localparam int unsigned RADIX_W = 6;
  localparam int unsigned DIGIT_W = 4;

  localparam logic [CH_W-1:0] CH_NUL  = 8'h00;
  localparam logic [CH_W-1:0] CH_ZERO = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE = 8'h39;
  localparam logic [CH_W-1:0] CH_A_UP = 8'h41;
  localparam logic [CH_W-1:0] CH_F_UP = 8'h46;
  localparam logic [CH_W-1:0] CH_X_UP = 8'h58;
  localparam logic [CH_W-1:0] CH_A_LO = 8'h61;
  localparam logic [CH_W-1:0] CH_F_LO = 8'h66;
  localparam logic [CH_W-1:0] CH_X_LO = 8'h78;
  localparam logic [CH_W-1:0] HEX_LETTER_BASE = 8'd10;

  localparam logic [RADIX_W-1:0] RADIX_AUTO = 6'd0;
  localparam logic [RADIX_W-1:0] RADIX_OCT  = 6'd8;
  localparam logic [RADIX_W-1:0] RADIX_DEC  = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_HEX  = 6'd16;

  typedef struct packed {
    logic               is_nul;
    logic               is_zero;
    logic               is_x;
    logic               is_hex;
    logic [DIGIT_W-1:0] digit;
  } itp_tok_t;

endpackage

FILE: hdl/itp_if.sv
// Channel interfaces of the integer text parser: character in, result out,
// radix register write. Each carries valid, ready and the payload.
// Depends on itp_pkg.
interface itp_ch_if import itp_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] ch;
  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

interface itp_res_if import itp_pkg::*; #(
  parameter int unsigned VALUE_WIDTH  = 64,
  parameter int unsigned OFFSET_WIDTH = 16
) ();
  logic                    valid;
  logic                    ready;
  logic [VALUE_WIDTH-1:0]  value;
  logic [OFFSET_WIDTH-1:0] end_offset;
  logic [RADIX_W-1:0]      radix_used;
  modport source (output valid, output value, output end_offset, output radix_used,
                  input ready);
  modport sink   (input valid, input value, input end_offset, input radix_used,
                  output ready);
endinterface

interface itp_cfg_if import itp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [RADIX_W-1:0] radix_setting;
  modport source (output valid, output radix_setting, input ready);
  modport sink   (input valid, input radix_setting, output ready);
endinterface

FILE: hdl/integer_text_parser_core.sv
// integer_text_parser_core: streaming unsigned integer text parser, top level.
// Holds the radix register and joins front, token queue and back.
// Depends on itp_pkg, itp_if, itp_front, itp_queue, itp_back.
//
//   channel   dir  payload                              transfer when
//   ch_chan   in   ch                                   valid && ready
//   res_chan  out  value, end_offset, radix_used        valid && ready
//   cfg_chan  in   radix_setting                        valid && ready (always ready)
//
// One character per cycle while the queue has room; a result leaves through
// the queue register and then the result register after its character is taken.
// The multiply-add of the accumulator in the back sets the cycle time.
// Reset clears the queue, the parse state and the radix register at once.
// A held result stalls the back only on a token that yields a new result;
// the two-entry queue then fills and ch_chan.ready drops.
module integer_text_parser_core import itp_pkg::*; #(
  parameter int unsigned VALUE_WIDTH  = 64,
  parameter int unsigned OFFSET_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  itp_ch_if.sink      ch_chan,
  itp_res_if.source   res_chan,
  itp_cfg_if.sink     cfg_chan
);

  logic [RADIX_W-1:0] radix_q;
  logic               q_ready, push, pop, q_valid;
  itp_tok_t           tok_in, tok_out;

  assign cfg_chan.ready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RADIX_AUTO;
    end else if (cfg_chan.valid && cfg_chan.ready) begin
      radix_q <= cfg_chan.radix_setting;
    end
  end

  itp_front u_front (
    .ch_valid_i (ch_chan.valid),
    .ch_ready_o (ch_chan.ready),
    .ch_i       (ch_chan.ch),
    .q_ready_i  (q_ready),
    .push_o     (push),
    .tok_o      (tok_in)
  );

  itp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .tok_i   (tok_in),
    .ready_o (q_ready),
    .pop_i   (pop),
    .valid_o (q_valid),
    .tok_o   (tok_out)
  );

  itp_back #(
    .VALUE_WIDTH  (VALUE_WIDTH),
    .OFFSET_WIDTH (OFFSET_WIDTH)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .radix_setting_i (radix_q),
    .tok_valid_i     (q_valid),
    .tok_i           (tok_out),
    .pop_o           (pop),
    .res_valid_o     (res_chan.valid),
    .res_ready_i     (res_chan.ready),
    .value_o         (res_chan.value),
    .end_offset_o    (res_chan.end_offset),
    .radix_used_o    (res_chan.radix_used)
  );

`ifndef SYNTH
  a_radix_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_chan.valid |-> res_chan.radix_used != RADIX_AUTO)
    else $error("result carries radix zero");

  a_result_from_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_chan.valid) |-> $past(q_valid))
    else $error("result appeared without a queued token");

  a_no_pop_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> q_valid)
    else $error("back consumed from an empty queue");
`endif

endmodule

FILE: hdl/itp_front.sv
// itp_front: accepts characters and classifies each one into a token.
// Pushes tokens into the queue; stalls when the queue is full.
// Depends on itp_pkg.
module itp_front import itp_pkg::*; (
  input  logic            ch_valid_i,
  output logic            ch_ready_o,
  input  logic [CH_W-1:0] ch_i,
  input  logic            q_ready_i,
  output logic            push_o,
  output itp_tok_t        tok_o
);

  logic is_dec, is_lo, is_up;

  always_comb begin
    is_dec = (ch_i >= CH_ZERO) && (ch_i <= CH_NINE);
    is_lo  = (ch_i >= CH_A_LO) && (ch_i <= CH_F_LO);
    is_up  = (ch_i >= CH_A_UP) && (ch_i <= CH_F_UP);
    tok_o.is_nul  = (ch_i == CH_NUL);
    tok_o.is_zero = (ch_i == CH_ZERO);
    tok_o.is_x    = (ch_i == CH_X_LO) || (ch_i == CH_X_UP);
    tok_o.is_hex  = is_dec || is_lo || is_up;
    if (is_dec) begin
      tok_o.digit = DIGIT_W'(ch_i - CH_ZERO);
    end else if (is_lo) begin
      tok_o.digit = DIGIT_W'(ch_i - CH_A_LO + HEX_LETTER_BASE);
    end else if (is_up) begin
      tok_o.digit = DIGIT_W'(ch_i - CH_A_UP + HEX_LETTER_BASE);
    end else begin
      tok_o.digit = '0;
    end
  end

  assign ch_ready_o = q_ready_i;
  assign push_o     = ch_valid_i && q_ready_i;

endmodule

FILE: hdl/itp_queue.sv
// itp_queue: two-entry token queue between front and back.
// Lets the front keep taking characters while the back waits on the output.
// Depends on itp_pkg.
module itp_queue import itp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  itp_tok_t tok_i,
  output logic     ready_o,
  input  logic     pop_i,
  output logic     valid_o,
  output itp_tok_t tok_o
);

  itp_tok_t   mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign ready_o = (count_q != 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign tok_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= tok_i;
    end
  end

endmodule

FILE: hdl/itp_back.sv
// itp_back: prefix state machine, multiply-add accumulator and result register.
// Consumes one token a cycle unless a result is due and the output is held.
// Depends on itp_pkg.
module itp_back import itp_pkg::*; #(
  parameter int unsigned VALUE_WIDTH  = 64,
  parameter int unsigned OFFSET_WIDTH = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [RADIX_W-1:0]      radix_setting_i,
  input  logic                    tok_valid_i,
  input  itp_tok_t                tok_i,
  output logic                    pop_o,
  output logic                    res_valid_o,
  input  logic                    res_ready_i,
  output logic [VALUE_WIDTH-1:0]  value_o,
  output logic [OFFSET_WIDTH-1:0] end_offset_o,
  output logic [RADIX_W-1:0]      radix_used_o
);

  localparam int unsigned PROD_W = VALUE_WIDTH + RADIX_W;

  typedef enum logic [2:0] {
    PH_START, PH_ZERO_AUTO, PH_ZEROX_AUTO, PH_ZERO_HEX, PH_DIGITS, PH_SKIP
  } phase_e;

  phase_e                  phase_q, phase_d;
  logic [VALUE_WIDTH-1:0]  acc_q, acc_d, acc_base;
  logic [OFFSET_WIDTH-1:0] pos_q, pos_d, pos_base;
  logic [RADIX_W-1:0]      rad_q, rad_d;
  logic                    do_digit, emit, accept, slot_free;
  logic [PROD_W-1:0]       prod;

  logic                    res_valid_q;
  logic [VALUE_WIDTH-1:0]  value_q;
  logic [OFFSET_WIDTH-1:0] offset_q;
  logic [RADIX_W-1:0]      radix_q;

  always_comb begin
    phase_d  = phase_q;
    rad_d    = rad_q;
    acc_base = acc_q;
    pos_base = pos_q;
    do_digit = 1'b0;
    emit     = 1'b0;
    case (phase_q)
      PH_START: begin
        acc_base = '0;
        pos_base = '0;
        if (radix_setting_i == RADIX_AUTO) begin
          if (tok_i.is_zero) begin
            phase_d = PH_ZERO_AUTO;
          end else begin
            rad_d    = RADIX_DEC;
            do_digit = 1'b1;
          end
        end else begin
          rad_d = radix_setting_i;
          if (radix_setting_i == RADIX_HEX && tok_i.is_zero) begin
            phase_d = PH_ZERO_HEX;
          end else begin
            do_digit = 1'b1;
          end
        end
      end
      PH_ZERO_AUTO: begin
        if (tok_i.is_x) begin
          phase_d = PH_ZEROX_AUTO;
        end else begin
          rad_d    = RADIX_OCT;
          acc_base = '0;
          pos_base = OFFSET_WIDTH'(1);
          do_digit = 1'b1;
        end
      end
      PH_ZEROX_AUTO: begin
        acc_base = '0;
        if (tok_i.is_hex) begin
          rad_d    = RADIX_HEX;
          pos_base = OFFSET_WIDTH'(2);
          do_digit = 1'b1;
        end else begin
          rad_d    = RADIX_OCT;
          pos_base = OFFSET_WIDTH'(1);
          emit     = 1'b1;
        end
      end
      PH_ZERO_HEX: begin
        acc_base = '0;
        if (tok_i.is_x) begin
          pos_base = OFFSET_WIDTH'(2);
          phase_d  = PH_DIGITS;
        end else begin
          pos_base = OFFSET_WIDTH'(1);
          do_digit = 1'b1;
        end
      end
      PH_DIGITS: begin
        do_digit = 1'b1;
      end
      PH_SKIP: begin
        if (tok_i.is_nul) begin
          phase_d = PH_START;
        end
      end
      default: begin
        phase_d = PH_START;
      end
    endcase

    accept = do_digit && tok_i.is_hex && (RADIX_W'(tok_i.digit) < rad_d);
    prod   = PROD_W'(acc_base) * PROD_W'(rad_d);
    acc_d  = acc_base;
    pos_d  = pos_base;
    if (accept) begin
      acc_d   = prod[VALUE_WIDTH-1:0] + VALUE_WIDTH'(tok_i.digit);
      pos_d   = (&pos_base) ? pos_base : pos_base + OFFSET_WIDTH'(1);
      phase_d = PH_DIGITS;
    end else if (do_digit) begin
      emit = 1'b1;
    end
    if (emit) begin
      phase_d = tok_i.is_nul ? PH_START : PH_SKIP;
    end
  end

  assign slot_free = !res_valid_q || res_ready_i;
  assign pop_o     = tok_valid_i && (!emit || slot_free);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_START;
      acc_q       <= '0;
      pos_q       <= '0;
      rad_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        phase_q <= phase_d;
        acc_q   <= acc_d;
        pos_q   <= pos_d;
        rad_q   <= rad_d;
      end
      if (pop_o && emit) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && emit) begin
      value_q  <= acc_d;
      offset_q <= pos_d;
      radix_q  <= rad_d;
    end
  end

  assign res_valid_o  = res_valid_q;
  assign value_o      = value_q;
  assign end_offset_o = offset_q;
  assign radix_used_o = radix_q;

endmodule
